/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of i_clk, skipped while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* hw/rtl/qsida_pkg.sv */
// Package: widths, codes and beat types of the stream ID admission block.
`timescale 1ns / 1ps

package qsida_pkg;

    localparam int ID_W   = 62;
    localparam int LIM_W  = 61;
    localparam int SEQ_W  = ID_W - 2;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int REG_W  = 3;

    // Queue between front and back; depth must be a power of two.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [ID_W-1:0] ID_STEP = ID_W'(4);
    localparam logic [ID_W-1:0] UNI_BIT = ID_W'(2);

    typedef enum logic [1:0] {
        OP_OPEN_BIDI = 2'd0,
        OP_OPEN_UNI  = 2'd1,
        OP_RESOLVE   = 2'd2,
        OP_RESET     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [REG_W-1:0] {
        REG_SERVER_ROLE     = 3'd0,
        REG_PEER_LIMIT_BIDI = 3'd1,
        REG_PEER_LIMIT_UNI  = 3'd2,
        REG_OWN_LIMIT_BIDI  = 3'd3,
        REG_OWN_LIMIT_UNI   = 3'd4
    } t_reg;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] request_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] result_id;
        logic            newly_opened;
        logic [ID_W-1:0] first_opened_id;
    } t_out_item;

    typedef struct packed {
        logic             server_role;
        logic [LIM_W-1:0] peer_limit_bidi;
        logic [LIM_W-1:0] peer_limit_uni;
        logic [LIM_W-1:0] own_limit_bidi;
        logic [LIM_W-1:0] own_limit_uni;
    } t_cfg;

    // Classified request as it travels from front to back.
    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] request_id;
        logic            own_side;
        logic            is_bidi;
        logic            over_own_limit;
    } t_cmd;

endpackage

/* hw/rtl/qsida_front.sv */
// Front end: accepts request beats and classifies them for the back end.
`timescale 1ns / 1ps

module qsida_front (
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  qsida_pkg::t_in_item i_in_item,
    input  qsida_pkg::t_cfg     i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output qsida_pkg::t_cmd     o_cmd
);

    logic [qsida_pkg::LIM_W-1:0] own_limit;
    logic                        is_bidi;

    assign is_bidi   = ~i_in_item.request_id[1];
    assign own_limit = is_bidi ? i_cfg.own_limit_bidi : i_cfg.own_limit_uni;

    always_comb begin
        o_cmd.op             = qsida_pkg::t_op'(i_in_item.operation);
        o_cmd.request_id     = i_in_item.request_id;
        o_cmd.own_side       = (i_in_item.request_id[0] == i_cfg.server_role);
        o_cmd.is_bidi        = is_bidi;
        // Sequence number of the ID against our limit for its type.
        o_cmd.over_own_limit = ({1'b0, i_in_item.request_id[qsida_pkg::ID_W-1:2]}
                                >= own_limit);
    end

    assign o_in_ready = ~i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

endmodule

/* hw/rtl/qsida_fifo.sv */
// Short queue of classified requests between front and back end.
`timescale 1ns / 1ps

module qsida_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qsida_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output qsida_pkg::t_cmd o_cmd
);

    qsida_pkg::t_cmd                r_mem [qsida_pkg::QDEPTH];
    logic [qsida_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [qsida_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [qsida_pkg::QCNT_W-1:0]   r_count;
    logic [qsida_pkg::QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == qsida_pkg::QCNT_W'(qsida_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/qsida_back.sv */
// Back end: stream counters, admission decision and result register.
`timescale 1ns / 1ps

module qsida_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qsida_pkg::t_cfg      i_cfg,
    input  logic                 i_q_valid,
    input  qsida_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output qsida_pkg::t_out_item o_out_item
);

    localparam int IW = qsida_pkg::ID_W;

    logic [IW-1:0] r_next_bidi, n_next_bidi;
    logic [IW-1:0] r_next_uni,  n_next_uni;
    logic [IW-1:0] r_top_bidi,  n_top_bidi;
    logic [IW-1:0] r_top_uni,   n_top_uni;
    logic          r_seen_bidi, n_seen_bidi;
    logic          r_seen_uni,  n_seen_uni;

    logic                  r_out_valid;
    qsida_pkg::t_out_item  r_out;
    qsida_pkg::t_out_item  n_out;

    logic                        fire;
    logic [IW-1:0]               open_ctr;
    logic [qsida_pkg::LIM_W-1:0] open_limit;
    logic [qsida_pkg::SEQ_W-1:0] open_seq;
    logic                        open_ok;
    logic [IW-1:0]               local_ctr;
    logic [IW-1:0]               peer_top;
    logic                        peer_seen;

    // Advance when a request waits and the result register is free or being drained.
    assign fire  = i_q_valid & (~r_out_valid | i_out_ready);
    assign o_pop = fire;

    assign open_ctr   = (i_cmd.op == qsida_pkg::OP_OPEN_UNI) ? r_next_uni : r_next_bidi;
    assign open_limit = (i_cmd.op == qsida_pkg::OP_OPEN_UNI) ? i_cfg.peer_limit_uni
                                                            : i_cfg.peer_limit_bidi;
    assign open_seq   = open_ctr[IW-1:2];
    // Refuse once the sequence reaches the peer limit or the last value of the ID space.
    assign open_ok    = ({1'b0, open_seq} < open_limit) & ~(&open_seq);

    assign local_ctr = i_cmd.is_bidi ? r_next_bidi : r_next_uni;
    assign peer_top  = i_cmd.is_bidi ? r_top_bidi  : r_top_uni;
    assign peer_seen = i_cmd.is_bidi ? r_seen_bidi : r_seen_uni;

    always_comb begin
        n_next_bidi = r_next_bidi;
        n_next_uni  = r_next_uni;
        n_top_bidi  = r_top_bidi;
        n_top_uni   = r_top_uni;
        n_seen_bidi = r_seen_bidi;
        n_seen_uni  = r_seen_uni;
        n_out       = '0;
        case (i_cmd.op)
            qsida_pkg::OP_OPEN_BIDI, qsida_pkg::OP_OPEN_UNI: begin
                if (open_ok) begin
                    n_out.status          = qsida_pkg::ST_OK;
                    n_out.result_id       = open_ctr;
                    n_out.newly_opened    = 1'b1;
                    n_out.first_opened_id = open_ctr;
                    if (i_cmd.op == qsida_pkg::OP_OPEN_UNI) begin
                        n_next_uni = open_ctr + qsida_pkg::ID_STEP;
                    end else begin
                        n_next_bidi = open_ctr + qsida_pkg::ID_STEP;
                    end
                end else begin
                    n_out.status = qsida_pkg::ST_LIMIT;
                end
            end
            qsida_pkg::OP_RESOLVE: begin
                n_out.result_id = i_cmd.request_id;
                if (i_cmd.own_side) begin
                    n_out.status = (i_cmd.request_id >= local_ctr) ? qsida_pkg::ST_INVALID
                                                                   : qsida_pkg::ST_OK;
                end else if (peer_seen && (i_cmd.request_id <= peer_top)) begin
                    n_out.status = qsida_pkg::ST_OK;
                end else if (i_cmd.over_own_limit) begin
                    n_out.status = qsida_pkg::ST_LIMIT;
                end else begin
                    // Open every ID of this type from the first unopened one.
                    n_out.status          = qsida_pkg::ST_OK;
                    n_out.newly_opened    = 1'b1;
                    n_out.first_opened_id = peer_seen ? (peer_top + qsida_pkg::ID_STEP)
                                          : {{(IW-2){1'b0}}, i_cmd.request_id[1:0]};
                    if (i_cmd.is_bidi) begin
                        n_top_bidi  = i_cmd.request_id;
                        n_seen_bidi = 1'b1;
                    end else begin
                        n_top_uni  = i_cmd.request_id;
                        n_seen_uni = 1'b1;
                    end
                end
            end
            qsida_pkg::OP_RESET: begin
                n_next_bidi = {{(IW-1){1'b0}}, i_cfg.server_role};
                n_next_uni  = qsida_pkg::UNI_BIT | {{(IW-1){1'b0}}, i_cfg.server_role};
                n_top_bidi  = '0;
                n_top_uni   = '0;
                n_seen_bidi = 1'b0;
                n_seen_uni  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Server role resets to client, so counters start at 0 and 2.
            r_next_bidi <= '0;
            r_next_uni  <= qsida_pkg::UNI_BIT;
            r_top_bidi  <= '0;
            r_top_uni   <= '0;
            r_seen_bidi <= 1'b0;
            r_seen_uni  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_next_bidi <= n_next_bidi;
                r_next_uni  <= n_next_uni;
                r_top_bidi  <= n_top_bidi;
                r_top_uni   <= n_top_uni;
                r_seen_bidi <= n_seen_bidi;
                r_seen_uni  <= n_seen_uni;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* hw/rtl/quic_stream_id_admission_top.sv */
// Top level: configuration registers, front end, request queue and back end.
`timescale 1ns / 1ps

// Stream ID admission for one QUIC connection. Each request beat either opens
// a local bidirectional or unidirectional stream (operation 0/1), resolves a
// stream ID received from the peer (operation 2) or reloads the counters
// (operation 3); every request gives exactly one result beat. The block takes
// one request per clock cycle while the queue has room and results are taken:
// the front end classifies a request in the cycle it is accepted and pushes it
// into a two-entry queue, and the back end updates its counters and loads the
// result register from the queue head, so a request passes through a queue
// entry and the result register before its result is on the output. Registers
// sit at byte addresses 0x00 (server_role), 0x08 and 0x10 (peer limits
// bidi/uni), 0x18 and 0x20 (own limits bidi/uni), 64 bits wide; write them
// only while no request is in flight. Changing server_role takes effect on the
// counters only after a reload request, as reset clears it to client.
module quic_stream_id_admission_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  qsida_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output qsida_pkg::t_out_item             o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qsida_pkg::ADDR_W-1:0]     paddr,
    input  logic [qsida_pkg::DATA_W-1:0]     pwdata,
    output logic [qsida_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int LW = qsida_pkg::LIM_W;
    localparam int DW = qsida_pkg::DATA_W;

    qsida_pkg::t_cfg r_cfg;
    qsida_pkg::t_reg reg_sel;
    logic            cfg_wr;

    qsida_pkg::t_cmd front_cmd;
    qsida_pkg::t_cmd q_cmd;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    assign pready  = 1'b1;
    assign reg_sel = qsida_pkg::t_reg'(paddr[qsida_pkg::ADDR_W-1:3]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                qsida_pkg::REG_SERVER_ROLE:     r_cfg.server_role     <= pwdata[0];
                qsida_pkg::REG_PEER_LIMIT_BIDI: r_cfg.peer_limit_bidi <= pwdata[LW-1:0];
                qsida_pkg::REG_PEER_LIMIT_UNI:  r_cfg.peer_limit_uni  <= pwdata[LW-1:0];
                qsida_pkg::REG_OWN_LIMIT_BIDI:  r_cfg.own_limit_bidi  <= pwdata[LW-1:0];
                qsida_pkg::REG_OWN_LIMIT_UNI:   r_cfg.own_limit_uni   <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            qsida_pkg::REG_SERVER_ROLE:     prdata = {{(DW-1){1'b0}}, r_cfg.server_role};
            qsida_pkg::REG_PEER_LIMIT_BIDI: prdata = {{(DW-LW){1'b0}}, r_cfg.peer_limit_bidi};
            qsida_pkg::REG_PEER_LIMIT_UNI:  prdata = {{(DW-LW){1'b0}}, r_cfg.peer_limit_uni};
            qsida_pkg::REG_OWN_LIMIT_BIDI:  prdata = {{(DW-LW){1'b0}}, r_cfg.own_limit_bidi};
            qsida_pkg::REG_OWN_LIMIT_UNI:   prdata = {{(DW-LW){1'b0}}, r_cfg.own_limit_uni};
            default:                        prdata = '0;
        endcase
    end

    qsida_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    qsida_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (q_cmd)
    );

    qsida_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* hw/rtl/qsida_checker.sv */
// Port-level checker for the stream ID admission block, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qsida_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input qsida_pkg::t_out_item o_out_item,
    input logic                 pready
);

    `ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready dropped")
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "result beat changed while stalled")
    `ASSERT_CLK(a_no_out_after_reset, $rose(i_rst_n) |-> !o_out_valid, "result beat right after reset")
    `ASSERT_CLK(a_first_zero, o_out_valid && !o_out_item.newly_opened |-> o_out_item.first_opened_id == '0, "first_opened_id set without an open")
    `ASSERT_CLK(a_limit_no_open, o_out_valid && o_out_item.status == qsida_pkg::ST_LIMIT |-> !o_out_item.newly_opened, "stream opened on a refused request")

endmodule

bind quic_stream_id_admission_top qsida_checker u_qsida_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .pready      (pready)
);
